[rtl/ies_pkg.sv]
// ies_pkg: item, result and record types, operation, kind and phase codes
// for the interrupt entry sequencer; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ies_pkg;

  // input operation codes
  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_ENABLE  = 2'd2;
  localparam logic [1:0] OP_START   = 2'd3;

  // result kinds
  localparam logic [2:0] K_IGNORED  = 3'd0;
  localparam logic [2:0] K_READ     = 3'd1;
  localparam logic [2:0] K_WRITE    = 3'd2;
  localparam logic [2:0] K_LMASK    = 3'd3;
  localparam logic [2:0] K_LSTATUS  = 3'd4;
  localparam logic [2:0] K_LCOUNTER = 3'd5;
  localparam logic [2:0] K_CLEAR    = 3'd6;
  localparam logic [2:0] K_ERROR    = 3'd7;

  // sequence phases
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_LINK    = 3'd1;
  localparam logic [2:0] PH_SERVICE = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_STATUS  = 3'd4;
  localparam logic [2:0] PH_COUNTER = 3'd5;

  localparam logic [15:0] ALWAYS_ENABLED_RESET = 16'h0023;
  localparam int unsigned MAX_RESULTS = 4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  interrupt_number;
    logic [15:0] current_mask;
    logic [15:0] current_status;
    logic [15:0] current_counter;
    logic [15:0] read_data;
    logic        enable_value;
  } item_t;

  // one result without its end mark
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] address;
    logic [15:0] data;
    logic [3:0]  pending_bit;
  } entry_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] address;
    logic [15:0] data;
    logic [3:0]  pending_bit;
    logic        last;
  } result_t;

  // all results caused by one item
  typedef struct packed {
    logic                           any;
    logic [1:0]                     last_slot;
    entry_t [MAX_RESULTS-1:0]       entries;
  } bundle_t;

endpackage

`default_nettype wire

[rtl/ies_req_if.sv]
// ies_req_if: valid/ready channel carrying one input item
// depends on ies_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ies_req_if;
  import ies_pkg::*;

  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/ies_rsp_if.sv]
// ies_rsp_if: valid/ready channel carrying one result item
// depends on ies_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ies_rsp_if;
  import ies_pkg::*;

  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/ies_engine.sv]
// ies_engine: sequencer state and the single-pass logic that turns one
// accepted item into its result bundle; depends on ies_pkg
`timescale 1ns / 1ps
`default_nettype none

module ies_engine (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [15:0]     linkage_base,
  input  wire logic            wr_en,
  input  wire logic [15:0]     wr_data,
  input  wire logic            accept,
  input  wire ies_pkg::item_t  item,
  output ies_pkg::bundle_t     bundle
);
  import ies_pkg::*;

  logic [15:0] always_enabled_mask;
  logic        interrupts_enabled;
  logic        last_valid;
  logic [3:0]  last_number;
  logic [15:0] interrupted_counter;
  logic [15:0] saved_mask;
  logic [15:0] saved_status;
  logic [2:0]  phase;

  logic        interrupts_enabled_next;
  logic        last_valid_next;
  logic [2:0]  phase_next;
  logic        take_request;
  logic        busy;
  logic [15:0] rd;

  assign busy = (phase >= PH_LINK) && (phase <= PH_COUNTER);
  assign rd   = item.read_data;

  // build the result bundle and next control state
  always_comb begin
    bundle                  = '0;
    interrupts_enabled_next = interrupts_enabled;
    last_valid_next         = last_valid;
    phase_next              = phase;
    take_request            = 1'b0;
    case (item.operation)
      OP_REQUEST: begin
        bundle.any = 1'b1;
        if (busy) begin
          bundle.entries[0].kind = K_ERROR;
        end else if (!interrupts_enabled &&
                     !always_enabled_mask[item.interrupt_number]) begin
          bundle.entries[0].kind = K_IGNORED;
        end else begin
          take_request            = 1'b1;
          interrupts_enabled_next = 1'b0;
          last_valid_next         = 1'b1;
          phase_next              = PH_LINK;
          bundle.entries[0].kind    = K_READ;
          bundle.entries[0].address =
            linkage_base + {11'd0, item.interrupt_number, 1'b0};
        end
      end
      OP_READ: begin
        bundle.any = 1'b1;
        case (phase)
          PH_LINK: begin
            bundle.last_slot = 2'd3;
            bundle.entries[0] = '{K_WRITE, rd, saved_mask, 4'd0};
            bundle.entries[1] = '{K_WRITE, rd + 16'd1, saved_status, 4'd0};
            bundle.entries[2] = '{K_WRITE, rd + 16'd2, interrupted_counter, 4'd0};
            bundle.entries[3] = '{K_READ, linkage_base + {11'd0, last_number, 1'b1},
                                  16'd0, 4'd0};
            phase_next = PH_SERVICE;
          end
          PH_SERVICE: begin
            bundle.last_slot = 2'd2;
            bundle.entries[0] = '{K_READ, rd, 16'd0, 4'd0};
            bundle.entries[1] = '{K_READ, rd + 16'd1, 16'd0, 4'd0};
            bundle.entries[2] = '{K_READ, rd + 16'd2, 16'd0, 4'd0};
            phase_next = PH_MASK;
          end
          PH_MASK: begin
            bundle.entries[0] = '{K_LMASK, 16'd0, rd, 4'd0};
            phase_next = PH_STATUS;
          end
          PH_STATUS: begin
            bundle.entries[0] = '{K_LSTATUS, 16'd0, rd, 4'd0};
            phase_next = PH_COUNTER;
          end
          PH_COUNTER: begin
            bundle.entries[0] = '{K_LCOUNTER, 16'd0, rd, 4'd0};
            phase_next = PH_IDLE;
          end
          default: begin
            bundle.entries[0].kind = K_ERROR;
          end
        endcase
      end
      OP_ENABLE: begin
        interrupts_enabled_next = item.enable_value;
      end
      OP_START: begin
        if (busy) begin
          bundle.any = 1'b1;
          bundle.entries[0].kind = K_ERROR;
        end else if (last_valid && (interrupted_counter == item.current_counter)) begin
          bundle.any = 1'b1;
          bundle.entries[0].kind        = K_CLEAR;
          bundle.entries[0].pending_bit = last_number;
          last_valid_next = 1'b0;
        end
      end
      default: begin
        bundle = '0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      always_enabled_mask <= ALWAYS_ENABLED_RESET;
      interrupts_enabled  <= 1'b1;
      last_valid          <= 1'b0;
      phase               <= PH_IDLE;
    end else begin
      if (wr_en) begin
        always_enabled_mask <= wr_data;
      end
      if (accept) begin
        interrupts_enabled <= interrupts_enabled_next;
        last_valid         <= last_valid_next;
        phase              <= phase_next;
      end
    end
  end

  // context captured when a request is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      last_number         <= 4'd0;
      interrupted_counter <= 16'd0;
      saved_mask          <= 16'd0;
      saved_status        <= 16'd0;
    end else if (accept && take_request) begin
      last_number         <= item.interrupt_number;
      interrupted_counter <= item.current_counter;
      saved_mask          <= item.current_mask;
      saved_status        <= item.current_status;
    end
  end

endmodule

`default_nettype wire

[rtl/interrupt_entry_sequencer_core.sv]
// interrupt_entry_sequencer_core: top level, engine plus result buffer that hands out one
// result per cycle if rsp is ready; depends on ies_pkg, ies_req_if, ies_rsp_if, ies_engine
//
//   channel  | dir | handshake     | content
//   req      | in  | valid/ready   | operation, interrupt number, registers, read data
//   rsp      | out | valid/ready   | kind, address, data, pending bit, last
//   wr_*     | in  | enable only   | always-enabled interrupt mask
//
// An item is worked in the cycle it is accepted; its results sit in the
// result buffer from the next cycle on, one handed out per cycle while rsp is ready.
// An item with one result or none can follow every cycle while rsp is ready; an
// item with more results stalls the input until its last one is taken from the
// single result buffer. Output stalls hold the buffer and the input; reset is
// synchronous, and the block accepts items from the first cycle after it.
`timescale 1ns / 1ps
`default_nettype none

module interrupt_entry_sequencer_core #(
  parameter logic [15:0] LINKAGE_BASE = 16'd32
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    wr_en,
  input  wire logic [15:0] wr_data,
  ies_req_if.sink      req,
  ies_rsp_if.source    rsp
);
  import ies_pkg::*;

  bundle_t  bundle;
  logic     accept;
  logic     take;
  logic     done;
  logic     buf_valid;
  logic [1:0] slot;
  logic [1:0] last_slot;
  entry_t [MAX_RESULTS-1:0] entries;

  assign take   = rsp.valid && rsp.ready;
  assign done   = take && (slot == last_slot);
  assign req.ready = !buf_valid || done;
  assign accept = req.valid && req.ready;

  ies_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .linkage_base (LINKAGE_BASE),
    .wr_en        (wr_en),
    .wr_data      (wr_data),
    .accept       (accept),
    .item         (req.payload),
    .bundle       (bundle)
  );

  // result buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      slot      <= 2'd0;
    end else if (accept) begin
      buf_valid <= bundle.any;
      slot      <= 2'd0;
    end else if (take) begin
      if (done) begin
        buf_valid <= 1'b0;
      end else begin
        slot <= slot + 2'd1;
      end
    end
  end

  // result buffer payload
  always_ff @(posedge clk) begin
    if (accept) begin
      entries   <= bundle.entries;
      last_slot <= bundle.last_slot;
    end
  end

  // output stage
  assign rsp.valid               = buf_valid;
  assign rsp.payload.kind        = entries[slot].kind;
  assign rsp.payload.address     = entries[slot].address;
  assign rsp.payload.data        = entries[slot].data;
  assign rsp.payload.pending_bit = entries[slot].pending_bit;
  assign rsp.payload.last        = (slot == last_slot);

  // input is only taken once the buffered results are gone
  a_accept_after_drain: assert property (@(posedge clk) disable iff (rst)
    accept |-> (!buf_valid || done))
    else $error("item accepted over undelivered results");

  // slot never runs past the final result of the bundle
  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    buf_valid |-> (slot <= last_slot))
    else $error("result slot beyond bundle end");

  // a partially delivered bundle moves to its next slot
  a_slot_step: assert property (@(posedge clk) disable iff (rst)
    (take && !done && !accept) |=> (buf_valid && (slot == $past(slot) + 2'd1)))
    else $error("result slot did not advance");

  // buffer is empty after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !buf_valid)
    else $error("result buffer not empty after reset");

endmodule

`default_nettype wire

[verif/interrupt_entry_sequencer_core_tb.sv]
// interrupt_entry_sequencer_core_tb: self-checking bench for the interrupt entry sequencer
// predicts every result from its own copy of the sequencer state and checks each one
// depends on ies_pkg, ies_req_if, ies_rsp_if and interrupt_entry_sequencer_core
`timescale 1ns / 1ps

import ies_pkg::*;

// entry sequence predictor and queue of the results still owed by the block
class entry_scoreboard;
  localparam logic [15:0] VECTOR_BASE = 16'd32;

  logic [15:0] always_on;
  bit          enabled;
  bit          rec_valid;
  logic [3:0]  rec_number;
  logic [15:0] rec_counter;
  logic [15:0] rec_mask;
  logic [15:0] rec_status;
  logic [2:0]  seq_phase;
  result_t     owed_q[$];
  int unsigned errors;

  function new();
    always_on   = ALWAYS_ENABLED_RESET;
    enabled     = 1'b1;
    rec_valid   = 1'b0;
    rec_number  = '0;
    rec_counter = '0;
    rec_mask    = '0;
    rec_status  = '0;
    seq_phase   = PH_IDLE;
    errors      = 0;
  endfunction

  function void set_always_on(logic [15:0] value);
    always_on = value;
  endfunction

  function result_t mk(logic [2:0] kind, logic [15:0] addr, logic [15:0] data,
                       logic [3:0] pbit);
    result_t r;
    r.kind        = kind;
    r.address     = addr;
    r.data        = data;
    r.pending_bit = pbit;
    r.last        = 1'b0;
    return r;
  endfunction

  // work out the results of one accepted item and append them
  function void note_item(item_t it);
    result_t     batch[$];
    bit          busy;
    logic [15:0] vec_addr;
    busy = (seq_phase >= PH_LINK) && (seq_phase <= PH_COUNTER);
    vec_addr = VECTOR_BASE + {11'd0, rec_number, 1'b0};
    case (it.operation)
      OP_REQUEST: begin
        if (busy) begin
          batch.push_back(mk(K_ERROR, '0, '0, '0));
        end else if (!enabled && !always_on[it.interrupt_number]) begin
          batch.push_back(mk(K_IGNORED, '0, '0, '0));
        end else begin
          enabled     = 1'b0;
          rec_valid   = 1'b1;
          rec_number  = it.interrupt_number;
          rec_counter = it.current_counter;
          rec_mask    = it.current_mask;
          rec_status  = it.current_status;
          seq_phase   = PH_LINK;
          batch.push_back(mk(K_READ, VECTOR_BASE + {11'd0, it.interrupt_number, 1'b0},
                             '0, '0));
        end
      end
      OP_READ: begin
        case (seq_phase)
          PH_LINK: begin
            batch.push_back(mk(K_WRITE, it.read_data, rec_mask, '0));
            batch.push_back(mk(K_WRITE, it.read_data + 16'd1, rec_status, '0));
            batch.push_back(mk(K_WRITE, it.read_data + 16'd2, rec_counter, '0));
            batch.push_back(mk(K_READ, vec_addr + 16'd1, '0, '0));
            seq_phase = PH_SERVICE;
          end
          PH_SERVICE: begin
            batch.push_back(mk(K_READ, it.read_data, '0, '0));
            batch.push_back(mk(K_READ, it.read_data + 16'd1, '0, '0));
            batch.push_back(mk(K_READ, it.read_data + 16'd2, '0, '0));
            seq_phase = PH_MASK;
          end
          PH_MASK: begin
            batch.push_back(mk(K_LMASK, '0, it.read_data, '0));
            seq_phase = PH_STATUS;
          end
          PH_STATUS: begin
            batch.push_back(mk(K_LSTATUS, '0, it.read_data, '0));
            seq_phase = PH_COUNTER;
          end
          PH_COUNTER: begin
            batch.push_back(mk(K_LCOUNTER, '0, it.read_data, '0));
            seq_phase = PH_IDLE;
          end
          default: batch.push_back(mk(K_ERROR, '0, '0, '0));
        endcase
      end
      OP_ENABLE: enabled = it.enable_value;
      default: begin
        if (busy) begin
          batch.push_back(mk(K_ERROR, '0, '0, '0));
        end else if (rec_valid && rec_counter == it.current_counter) begin
          batch.push_back(mk(K_CLEAR, '0, '0, rec_number));
          rec_valid = 1'b0;
        end
      end
    endcase
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) owed_q.push_back(batch[i]);
  endfunction

  function void mismatch(string field, logic [15:0] want, logic [15:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endfunction

  // compare one result with the oldest one owed
  function void check_result(result_t got);
    result_t want;
    if (owed_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual kind %0d addr %h data %h",
               $time, got.kind, got.address, got.data);
      return;
    end
    want = owed_q.pop_front();
    if (got.kind !== want.kind) mismatch("kind", want.kind, got.kind);
    if (got.address !== want.address) mismatch("address", want.address, got.address);
    if (got.data !== want.data) mismatch("data", want.data, got.data);
    if (got.pending_bit !== want.pending_bit)
      mismatch("pending_bit", want.pending_bit, got.pending_bit);
    if (got.last !== want.last) mismatch("last", want.last, got.last);
  endfunction
endclass

module interrupt_entry_sequencer_core_tb;
  import ies_pkg::*;

  localparam int LONG_HOLD   = 80;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 90;

  logic        clk;
  logic        rst;
  logic        wr_en;
  logic [15:0] wr_data;

  ies_req_if req_ch ();
  ies_rsp_if rsp_ch ();

  entry_scoreboard sb = new();

  bit          calm = 1'b0;
  bit          hold_output = 1'b0;
  int          send_quiet = 0;
  int          sink_quiet = 0;
  int unsigned sent_items = 0;
  int unsigned idle_cycles = 0;

  interrupt_entry_sequencer_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // edge-heavy 16-bit values
  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'hFFFE;
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic item_t rand_item();
    item_t it;
    it.operation        = 2'($urandom_range(0, 3));
    it.interrupt_number = 4'($urandom_range(0, 15));
    it.current_mask     = pick16();
    it.current_status   = pick16();
    it.current_counter  = pick16();
    it.read_data        = pick16();
    it.enable_value     = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // offer one item, with a random gap first, and wait until it is taken
  task automatic send_item(input item_t it);
    if (send_quiet > 0) begin
      send_quiet--;
    end else if (!calm && $urandom_range(0, 29) == 0) begin
      send_quiet = $urandom_range(15, 40);
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= it;
    do @(posedge clk); while (!req_ch.ready);
    sent_items++;
  endtask

  task automatic send_request(input logic [3:0] num, input logic [15:0] mask,
                              input logic [15:0] status, input logic [15:0] counter);
    item_t it;
    it = rand_item();
    it.operation        = OP_REQUEST;
    it.interrupt_number = num;
    it.current_mask     = mask;
    it.current_status   = status;
    it.current_counter  = counter;
    send_item(it);
  endtask

  task automatic send_word(input logic [15:0] word);
    item_t it;
    it = rand_item();
    it.operation = OP_READ;
    it.read_data = word;
    send_item(it);
  endtask

  task automatic send_enable(input logic value);
    item_t it;
    it = rand_item();
    it.operation    = OP_ENABLE;
    it.enable_value = value;
    send_item(it);
  endtask

  task automatic send_start(input logic [15:0] counter);
    item_t it;
    it = rand_item();
    it.operation       = OP_START;
    it.current_counter = counter;
    send_item(it);
  endtask

  // stop offering and wait until every owed result has arrived
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_always_on(input logic [15:0] value);
    wr_en   <= 1'b1;
    wr_data <= value;
    @(posedge clk);
    wr_en   <= 1'b0;
    sb.set_always_on(value);
  endtask

  // full interrupt entry with random content, optionally with stray items mixed in
  task automatic entry_sequence(input bit broken);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) send_enable(1'b1);
    else if (pick < 8) send_enable(1'b0);
    send_request(4'($urandom_range(0, 15)), pick16(), pick16(), pick16());
    for (int k = 0; k < 5; k++) begin
      if (broken && $urandom_range(0, 2) == 0) send_item(rand_item());
      send_word(pick16());
    end
    if ($urandom_range(0, 2) != 0) begin
      if ($urandom_range(0, 1) == 0) send_start(sb.rec_counter + 16'd1);
      send_start(sb.rec_counter);
    end
  endtask

  // result side: random stalls, quiet stretches and one long hold-off
  initial begin
    rsp_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_output) begin
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_output = 1'b0;
        rsp_ch.ready <= 1'b1;
      end else if (calm || sink_quiet > 0) begin
        if (sink_quiet > 0) sink_quiet--;
        rsp_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 29) == 0) begin
        sink_quiet = $urandom_range(20, 60);
        rsp_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // handshake monitor and progress watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.payload);
      if (req_ch.valid && req_ch.ready) sb.note_item(req_ch.payload);
      if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    logic [15:0] settings [5];
    int unsigned target;
    int          pick;
    settings[0] = 16'h0000;
    settings[1] = 16'hFFFF;
    settings[2] = 16'($urandom_range(0, 16'hFFFF));
    settings[3] = 16'h8421;
    settings[4] = ALWAYS_ENABLED_RESET;
    rst            <= 1'b1;
    wr_en          <= 1'b0;
    wr_data        <= '0;
    req_ch.valid   <= 1'b0;
    req_ch.payload <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: nothing recorded, idle read data, wrap-around pointers, errors while busy
    send_start(16'h0000);
    send_word(16'h1234);
    send_request(4'd15, 16'hFFFF, 16'h0000, 16'hFFFF);
    send_request(4'd3, 16'h5A5A, 16'hA5A5, 16'h0001);
    send_start(16'hFFFF);
    send_enable(1'b1);
    send_word(16'hFFFF);
    send_word(16'hFFFE);
    send_word(16'h0000);
    send_word(16'hFFFF);
    send_word(16'h8000);
    send_start(16'hFFFE);
    send_start(16'hFFFF);
    send_start(16'hFFFF);
    // disabled: a plain level is ignored, an always-enabled level is taken
    send_enable(1'b0);
    send_request(4'd2, 16'h0F0F, 16'hF0F0, 16'h7FFF);
    send_request(4'd0, 16'h0000, 16'hFFFF, 16'h0000);
    send_word(16'h0000);
    send_word(16'hFFFF);
    send_word(16'h0001);
    send_word(16'h0002);
    send_word(16'h0003);
    send_start(16'h0000);

    // random phases, one always-enabled setting each
    for (int p = 0; p < 5; p++) begin
      drain();
      write_always_on(settings[p]);
      if (p == 1) hold_output = 1'b1;
      if (p == 4) calm = 1'b1;
      target = sent_items + PHASE_ITEMS;
      while (sent_items < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) entry_sequence(1'b0);
        else if (pick < 75) entry_sequence(1'b1);
        else if (pick < 90) send_item(rand_item());
        else send_enable(1'($urandom_range(0, 1)));
      end
    end

    // wait out the last results
    drain();
    repeat (10) @(posedge clk);
    if (sb.owed_q.size() != 0)
      $display("%0t: %0d results never arrived", $time, sb.owed_q.size());
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
